// ----- src/csvtok_pkg.sv -----
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared constants, result kinds and the controller/datapath command and
// status types of the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_QUOTE    = 8'd34;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FIELD,
        KIND_RECORD,
        KIND_CUT
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_CR,
        OP_CHAR,
        OP_HOLD_CR,
        OP_CLOSE,
        OP_FLUSH_OUT
    } op_t;

    typedef enum logic [1:0] {
        SEL_CR,
        SEL_BYTE,
        SEL_LF
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic cr_held;
        logic b_is_lf;
        logic b_is_cr;
        logic eot;
        logic char_done;
        logic stg_valid;
        logic can_push;
        logic out_free;
    } status_t;

endpackage

// ----- src/csvtok_if.sv -----
// ----------------------------------------------------------------------------
// csvtok_if
// Valid/ready stream interfaces: text bytes in, tokenized results out.
// ----------------------------------------------------------------------------
interface csvtok_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, end_of_text, output ready);

endinterface

interface csvtok_out_if import csvtok_pkg::*; ();

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    kind_t      kind;
    logic       ws_spill;
    logic       last_of_run;

    modport source (output valid, out_byte, kind, ws_spill, last_of_run, input ready);
    modport sink   (input valid, out_byte, kind, ws_spill, last_of_run, output ready);

endinterface

// ----- src/csvtok_dp.sv -----
// ----------------------------------------------------------------------------
// csvtok_dp
// Datapath: byte and delimiter registers, quote state, trailing whitespace
// buffer, at most one result per command, staging plus output registers.
// ----------------------------------------------------------------------------
module csvtok_dp import csvtok_pkg::*; #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    st,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output kind_t      out_kind,
    output logic       out_spill,
    output logic       out_last
);

    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [1:0] {
        QM_NORMAL,
        QM_QUOTED,
        QM_QSEEN
    } qmode_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CONT,
        ACT_FIELD,
        ACT_RECORD
    } act_t;

    logic [7:0]       b_reg, b_next;
    logic             eot_reg, eot_next;
    logic [7:0]       delim_reg;
    qmode_t           qm_reg, qm_next;
    logic             cr_held_reg, cr_held_next;
    logic             has_text_reg, has_text_next;
    logic             rec_phase_reg, rec_phase_next;
    logic [7:0]       pend_reg [PENDING_DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             stg_valid_reg, stg_valid_next;
    logic [7:0]       stg_byte_reg, stg_byte_next;
    kind_t            stg_kind_reg, stg_kind_next;
    logic             stg_spill_reg, stg_spill_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    kind_t            out_kind_reg, out_kind_next;
    logic             out_spill_reg, out_spill_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       c;
    logic             c_ws;
    act_t             act;
    qmode_t           qm_new;
    qmode_t           qm_hold;
    logic             full;
    logic             char_done;
    logic             push;
    logic             pop;
    logic             clr_field;
    logic             res_valid;
    logic [7:0]       res_byte;
    kind_t            res_kind;
    logic             res_spill;
    logic             out_free;
    logic             can_push;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;

    always_comb
    begin
        case (cmd.sel)
            SEL_CR:  c = CH_CR;
            SEL_LF:  c = CH_LF;
            default: c = b_reg;
        endcase
    end

    assign c_ws = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    assign full = (cnt_reg == CNT_W'(PENDING_DEPTH));

    assign head_inc = (head_reg == IDX_W'(PENDING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(PENDING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // decode one character against the quote state
    always_comb
    begin
        act    = ACT_CONT;
        qm_new = QM_NORMAL;
        if ((qm_reg == QM_QSEEN) && (c == CH_QUOTE))
        begin
            act    = ACT_CONT;
            qm_new = QM_QUOTED;
        end
        else if (qm_reg == QM_QUOTED)
        begin
            if (c == CH_QUOTE)
            begin
                act    = ACT_NONE;
                qm_new = QM_QSEEN;
            end
            else
            begin
                act    = ACT_CONT;
                qm_new = QM_QUOTED;
            end
        end
        else if (c == CH_LF)
        begin
            act = ACT_RECORD;
        end
        else if (c == delim_reg)
        begin
            act = ACT_FIELD;
        end
        else if (c == CH_QUOTE)
        begin
            act    = ACT_NONE;
            qm_new = QM_QUOTED;
        end
    end

    always_comb
    begin
        case (act)
            ACT_CONT:   char_done = c_ws || (cnt_reg == '0);
            ACT_RECORD: char_done = rec_phase_reg;
            default:    char_done = 1'b1;
        endcase
    end

    assign qm_hold = (qm_reg == QM_QSEEN) ? QM_NORMAL : qm_reg;

    always_comb
    begin
        b_next         = b_reg;
        eot_next       = eot_reg;
        qm_next        = qm_reg;
        cr_held_next   = cr_held_reg;
        has_text_next  = has_text_reg;
        rec_phase_next = rec_phase_reg;
        push           = 1'b0;
        pop            = 1'b0;
        clr_field      = 1'b0;
        res_valid      = 1'b0;
        res_byte       = '0;
        res_kind       = KIND_DATA;
        res_spill      = 1'b0;

        case (cmd.op)
            OP_LOAD:
            begin
                b_next   = in_byte;
                eot_next = end_of_text;
            end
            OP_CLR_CR:
            begin
                cr_held_next = 1'b0;
            end
            OP_CHAR:
            begin
                case (act)
                    ACT_CONT:
                    begin
                        if (c_ws)
                        begin
                            if (has_text_reg)
                            begin
                                push = 1'b1;
                                if (full)
                                begin
                                    pop       = 1'b1;
                                    res_valid = 1'b1;
                                    res_byte  = pend_reg[head_reg];
                                    res_spill = 1'b1;
                                end
                            end
                        end
                        else if (cnt_reg != '0)
                        begin
                            pop       = 1'b1;
                            res_valid = 1'b1;
                            res_byte  = pend_reg[head_reg];
                        end
                        else
                        begin
                            res_valid     = 1'b1;
                            res_byte      = c;
                            has_text_next = 1'b1;
                        end
                    end
                    ACT_FIELD:
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_FIELD;
                        clr_field = 1'b1;
                    end
                    ACT_RECORD:
                    begin
                        res_valid = 1'b1;
                        if (rec_phase_reg)
                        begin
                            res_kind       = KIND_RECORD;
                            clr_field      = 1'b1;
                            rec_phase_next = 1'b0;
                        end
                        else
                        begin
                            res_kind       = KIND_FIELD;
                            rec_phase_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (char_done)
                begin
                    qm_next = qm_new;
                    if (cmd.sel == SEL_CR)
                    begin
                        cr_held_next = 1'b0;
                    end
                end
            end
            OP_HOLD_CR:
            begin
                qm_next      = qm_hold;
                cr_held_next = 1'b1;
                if (((qm_hold == QM_QUOTED) || (delim_reg != CH_CR)) && has_text_reg && full)
                begin
                    pop       = 1'b1;
                    res_valid = 1'b1;
                    res_byte  = pend_reg[head_reg];
                    res_spill = 1'b1;
                end
            end
            OP_CLOSE:
            begin
                if (qm_reg != QM_NORMAL)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_CUT;
                end
                qm_next      = QM_NORMAL;
                cr_held_next = 1'b0;
                clr_field    = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (clr_field)
        begin
            has_text_next = 1'b0;
        end
    end

    always_comb
    begin
        if (clr_field)
        begin
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
        end
        else
        begin
            head_next = pop ? head_inc : head_reg;
            tail_next = push ? tail_inc : tail_reg;
            cnt_next  = cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign can_push = !stg_valid_reg || out_free;

    // hold the newest result in staging until the next one shows whether it is the last
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_byte_next  = stg_byte_reg;
        stg_kind_next  = stg_kind_reg;
        stg_spill_next = stg_spill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_spill_next = out_spill_reg;
        out_last_next  = out_last_reg;

        if (res_valid)
        begin
            if (stg_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = stg_byte_reg;
                out_kind_next  = stg_kind_reg;
                out_spill_next = stg_spill_reg;
                out_last_next  = 1'b0;
            end
            stg_valid_next = 1'b1;
            stg_byte_next  = res_byte;
            stg_kind_next  = res_kind;
            stg_spill_next = res_spill;
        end
        else if (cmd.op == OP_FLUSH_OUT)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = stg_byte_reg;
            out_kind_next  = stg_kind_reg;
            out_spill_next = stg_spill_reg;
            out_last_next  = 1'b1;
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= DELIM_RESET;
            qm_reg        <= QM_NORMAL;
            cr_held_reg   <= 1'b0;
            has_text_reg  <= 1'b0;
            rec_phase_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delim_reg <= cfg_wdata;
            end
            qm_reg        <= qm_next;
            cr_held_reg   <= cr_held_next;
            has_text_reg  <= has_text_next;
            rec_phase_reg <= rec_phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg         <= b_next;
        eot_reg       <= eot_next;
        stg_byte_reg  <= stg_byte_next;
        stg_kind_reg  <= stg_kind_next;
        stg_spill_reg <= stg_spill_next;
        out_byte_reg  <= out_byte_next;
        out_kind_reg  <= out_kind_next;
        out_spill_reg <= out_spill_next;
        out_last_reg  <= out_last_next;
        if (push)
        begin
            pend_reg[tail_reg] <= c;
        end
    end

    assign st.cr_held   = cr_held_reg;
    assign st.b_is_lf   = (b_reg == CH_LF);
    assign st.b_is_cr   = (b_reg == CH_CR);
    assign st.eot       = eot_reg;
    assign st.char_done = char_done;
    assign st.stg_valid = stg_valid_reg;
    assign st.can_push  = can_push;
    assign st.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;
    assign out_spill = out_spill_reg;
    assign out_last  = out_last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PENDING_DEPTH))
        else $error("pending count beyond buffer depth");

    a_pend_text: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> has_text_reg)
        else $error("pending whitespace without field text");

    a_cr_qm: assert property (@(posedge clk) disable iff (!rst_n)
        cr_held_reg |-> (qm_reg != QM_QSEEN))
        else $error("held CR with unresolved quote");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!stg_valid_reg || !out_valid_reg || out_ready))
        else $error("result produced with no room");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FLUSH_OUT) |=> (out_valid_reg && out_last_reg))
        else $error("final result not marked last");

endmodule

// ----- src/csvtok_ctrl.sv -----
// ----------------------------------------------------------------------------
// csvtok_ctrl
// Controller: walks each accepted byte through held-CR, main, end-of-text,
// close and final-result phases, one datapath command per cycle.
// ----------------------------------------------------------------------------
module csvtok_ctrl import csvtok_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRH,
        ST_MAIN,
        ST_EOT,
        ST_CUT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = SEL_BYTE;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CRH;
                end
            end
            ST_CRH:
            begin
                cmd.sel = SEL_CR;
                if (st.can_push)
                begin
                    if (st.cr_held && !st.b_is_lf)
                    begin
                        cmd.op = OP_CHAR;
                        if (st.char_done)
                        begin
                            state_next = ST_MAIN;
                        end
                    end
                    else
                    begin
                        cmd.op     = OP_CLR_CR;
                        state_next = ST_MAIN;
                    end
                end
            end
            ST_MAIN:
            begin
                if (st.can_push)
                begin
                    if (st.b_is_cr && !st.eot)
                    begin
                        cmd.op     = OP_HOLD_CR;
                        state_next = ST_EOT;
                    end
                    else
                    begin
                        cmd.op = OP_CHAR;
                        if (st.char_done)
                        begin
                            state_next = ST_EOT;
                        end
                    end
                end
            end
            ST_EOT:
            begin
                cmd.sel = SEL_LF;
                if (!st.eot)
                begin
                    state_next = ST_FIN;
                end
                else if (st.b_is_lf)
                begin
                    state_next = ST_CUT;
                end
                else if (st.can_push)
                begin
                    cmd.op = OP_CHAR;
                    if (st.char_done)
                    begin
                        state_next = ST_CUT;
                    end
                end
            end
            ST_CUT:
            begin
                if (st.can_push)
                begin
                    cmd.op     = OP_CLOSE;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!st.stg_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.op     = OP_FLUSH_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/csv_record_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming CSV tokenizer with quoted fields and whitespace trimming.
// ----------------------------------------------------------------------------
// Takes one text byte per transaction and returns data bytes, end-of-field,
// end-of-record and cut-off marks, one result per transaction, the last result
// of each byte flagged. Each byte passes through accept, held-CR step, byte
// step, end-of-text check and final-result flush, the flush step spent even
// when the byte yields nothing. The held-CR step, the byte step and the
// supplied line end each stay until they have produced every result they
// owe (flushed trailing whitespace, the second mark of a record end); the
// supplied line end runs in the end-of-text check's step. A final byte of
// the text adds a close step, which carries any cut-off mark. Output stalls
// hold the steps. The controller issues one datapath command a cycle and
// the datapath produces at most one result a cycle. The delimiter register
// may be rewritten only while no byte is in flight.
// ----------------------------------------------------------------------------
module csv_record_tokenizer import csvtok_pkg::*; #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    csvtok_in_if.sink   text,
    csvtok_out_if.source tokens,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    cmd_t    cmd;
    status_t st;
    logic    ready;

    csvtok_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    csvtok_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_byte     (text.in_byte),
        .end_of_text (text.end_of_text),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (tokens.valid),
        .out_ready   (tokens.ready),
        .out_byte    (tokens.out_byte),
        .out_kind    (tokens.kind),
        .out_spill   (tokens.ws_spill),
        .out_last    (tokens.last_of_run)
    );

    assign text.ready = ready;

endmodule
